@@ hdl/disparity_median_mad_filter_macros.svh @@
// Assertion macros shared by the checker of the disparity median/MAD filter.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef DISPARITY_MEDIAN_MAD_FILTER_MACROS_SVH
`define DISPARITY_MEDIAN_MAD_FILTER_MACROS_SVH

// Condition that must hold in the same cycle as its trigger.
`define DMF_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define DMF_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ hdl/dmf_pkg.sv @@
// Package of the disparity median/MAD filter: sizes, register codes, types, helpers.
// Depends on nothing.
`default_nettype none
package dmf_pkg;
	localparam int MAX_MATCHES = 64;
	localparam int IDX_W       = $clog2(MAX_MATCHES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int DATA_W      = 16;
	localparam int BIT_W       = $clog2(DATA_W);
	localparam int PROD_W      = DATA_W + 8;
	localparam int TOL_W       = PROD_W - 4;

	localparam logic [CNT_W-1:0]  SMALL_SET = CNT_W'(8);
	localparam logic [DATA_W-1:0] ONE_Q4    = DATA_W'(16);
	localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic CFG_MIN_TOL   = 1'b0;
	localparam logic CFG_MAD_SCALE = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MED  = 7'b0000010,
		ST_MAD  = 7'b0000100,
		ST_PROD = 7'b0001000,
		ST_TOL  = 7'b0010000,
		ST_CNT  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	typedef struct packed {
		logic             sample;
		logic             bit_end;
		logic [BIT_W-1:0] bit_idx;
	} rank_ctl_t;

	// Exact absolute difference of two signed Q12.4 values.
	function automatic logic [DATA_W-1:0] abs_dev(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W:0] d;
		logic [DATA_W:0] nd;
		d  = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		nd = -d;
		return d[DATA_W] ? nd[DATA_W-1:0] : d[DATA_W-1:0];
	endfunction
endpackage
`default_nettype wire

@@ hdl/dmf_ram.sv @@
// Disparity store: simple dual-port RAM with one registered read port.
// Depends on dmf_pkg.
`default_nettype none
module dmf_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [dmf_pkg::IDX_W-1:0]   waddr,
	input  wire logic [dmf_pkg::DATA_W-1:0]  wdata,
	input  wire logic [dmf_pkg::IDX_W-1:0]   raddr,
	output logic      [dmf_pkg::DATA_W-1:0]  rdata
);
	logic [dmf_pkg::DATA_W-1:0] mem [dmf_pkg::MAX_MATCHES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/dmf_rank.sv @@
// Bitwise rank search: one result bit per sweep over the stored values.
// Depends on dmf_pkg.
`default_nettype none
module dmf_rank (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dmf_pkg::rank_ctl_t          ctl,
	input  wire logic [dmf_pkg::DATA_W-1:0]  value,
	input  wire logic [dmf_pkg::IDX_W-1:0]   k,
	output logic      [dmf_pkg::DATA_W-1:0]  result
);
	logic [dmf_pkg::DATA_W-1:0] r_q;
	logic [dmf_pkg::CNT_W-1:0]  cnt_q;
	logic [dmf_pkg::DATA_W-1:0] trial;
	logic [dmf_pkg::CNT_W-1:0]  cnt_eff;
	logic                       lt;

	// The trial sets the current bit; it is kept while no more than k values lie below it.
	assign trial   = r_q | (dmf_pkg::DATA_W'(1) << ctl.bit_idx);
	assign lt      = ctl.sample && (value < trial);
	assign cnt_eff = cnt_q + dmf_pkg::CNT_W'(lt);
	assign result  = (cnt_eff <= {1'b0, k}) ? trial : r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			cnt_q <= '0;
		end else if (ctl.bit_end) begin
			cnt_q <= '0;
			r_q   <= (ctl.bit_idx == '0) ? '0 : result;
		end else begin
			cnt_q <= cnt_eff;
		end
	end
endmodule
`default_nettype wire

@@ hdl/disparity_median_mad_filter.sv @@
// Disparity median/MAD outlier filter. A beat is loaded in each cycle with start high and busy low.
// After the last beat of a set, busy stays high while sixteen sweeps of the store find the
// median, sixteen more the MAD, two steps form the tolerance, one sweep counts the kept
// matches and one emits the results, one per cycle, all over the single RAM read port.
// The results follow one per cycle on done; the receiver cannot stall them.
// Reset is asynchronous, active low; it empties the set and loads the register reset values.
`default_nettype none
module disparity_median_mad_filter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [14:0]                       cfg_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [dmf_pkg::DATA_W-1:0] disparity,
	input  wire logic                              last,
	output logic                                   done,
	output logic      [dmf_pkg::IDX_W-1:0]         match_index,
	output logic                                   keep,
	output logic                                   last_res,
	output logic                                   overflow
);
	// Configuration registers.
	logic [14:0] min_tol_q;
	logic [7:0]  mad_scale_q;

	// Sequencer and set bookkeeping.
	dmf_pkg::state_t             state_q;
	logic [dmf_pkg::CNT_W-1:0]   count_q;
	logic                        ovf_q;
	logic [dmf_pkg::CNT_W-1:0]   rd_idx_q;
	logic [dmf_pkg::BIT_W-1:0]   bit_q;
	logic                        sample_s1;
	logic [dmf_pkg::IDX_W-1:0]   idx_s1;

	// Statistics of the set.
	logic [dmf_pkg::DATA_W-1:0]  med_q;
	logic [dmf_pkg::DATA_W-1:0]  mad_q;
	logic [dmf_pkg::PROD_W-1:0]  prod_q;
	logic [dmf_pkg::TOL_W-1:0]   tol_q;
	logic [dmf_pkg::CNT_W-1:0]   kept_q;

	logic                        accept;
	logic                        sweeping;
	logic                        ranking;
	logic                        sweep_end;
	logic                        ram_we;
	logic [dmf_pkg::DATA_W-1:0]  rdata;
	logic [dmf_pkg::DATA_W-1:0]  dev;
	logic [dmf_pkg::DATA_W-1:0]  rank_value;
	logic [dmf_pkg::DATA_W-1:0]  rank_result;
	logic [dmf_pkg::DATA_W-1:0]  madq;
	logic                        dev_ok;
	logic                        all_keep;
	dmf_pkg::rank_ctl_t          rank_ctl;

	assign busy      = (state_q != dmf_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign ram_we    = accept && (count_q < dmf_pkg::CNT_W'(dmf_pkg::MAX_MATCHES));
	assign ranking   = (state_q == dmf_pkg::ST_MED) || (state_q == dmf_pkg::ST_MAD);
	assign sweeping  = ranking || (state_q == dmf_pkg::ST_CNT) || (state_q == dmf_pkg::ST_EMIT);
	// The read of the last entry was issued in the previous cycle, so its data is in hand now.
	assign sweep_end = sweeping && (rd_idx_q == count_q);

	dmf_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[dmf_pkg::IDX_W-1:0]),
		.wdata (disparity),
		.raddr (rd_idx_q[dmf_pkg::IDX_W-1:0]),
		.rdata (rdata)
	);

	// The median search runs on offset binary so that an unsigned compare orders signed values.
	assign dev        = dmf_pkg::abs_dev(rdata, med_q);
	assign rank_value = (state_q == dmf_pkg::ST_MED) ? (rdata ^ dmf_pkg::SIGN_FLIP) : dev;

	assign rank_ctl.sample  = sample_s1 && ranking;
	assign rank_ctl.bit_end = sweep_end && ranking;
	assign rank_ctl.bit_idx = bit_q;

	dmf_rank u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rank_ctl),
		.value  (rank_value),
		.k      (count_q[dmf_pkg::CNT_W-1:1]),
		.result (rank_result)
	);

	assign madq     = (mad_q < dmf_pkg::ONE_Q4) ? dmf_pkg::ONE_Q4 : mad_q;
	assign dev_ok   = ({{(dmf_pkg::TOL_W-dmf_pkg::DATA_W){1'b0}}, dev} <= tol_q);
	// Small sets, and sets where the test would keep fewer than floor(n/2) matches, keep everything.
	assign all_keep = (count_q < dmf_pkg::SMALL_SET) || (kept_q < {1'b0, count_q[dmf_pkg::CNT_W-1:1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tol_q   <= 15'd32;
			mad_scale_q <= 8'd48;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmf_pkg::CFG_MIN_TOL:   min_tol_q   <= cfg_data;
				dmf_pkg::CFG_MAD_SCALE: mad_scale_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dmf_pkg::ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			rd_idx_q  <= '0;
			bit_q     <= '0;
			sample_s1 <= 1'b0;
			kept_q    <= '0;
			done      <= 1'b0;
		end else begin
			sample_s1 <= sweeping && (rd_idx_q < count_q);
			done      <= (state_q == dmf_pkg::ST_EMIT) && sample_s1;
			if (sweeping) begin
				rd_idx_q <= sweep_end ? '0 : rd_idx_q + 1'b1;
			end
			if ((state_q == dmf_pkg::ST_CNT) && sample_s1 && dev_ok) begin
				kept_q <= kept_q + 1'b1;
			end
			unique case (state_q)
				dmf_pkg::ST_IDLE: begin
					if (accept) begin
						if (ram_we) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							state_q  <= dmf_pkg::ST_MED;
							rd_idx_q <= '0;
							bit_q    <= dmf_pkg::BIT_W'(dmf_pkg::DATA_W - 1);
						end
					end
				end
				dmf_pkg::ST_MED, dmf_pkg::ST_MAD: begin
					if (sweep_end) begin
						bit_q <= bit_q - 1'b1;
						if (bit_q == '0) begin
							state_q <= (state_q == dmf_pkg::ST_MED) ? dmf_pkg::ST_MAD
								: dmf_pkg::ST_PROD;
						end
					end
				end
				dmf_pkg::ST_PROD: begin
					state_q <= dmf_pkg::ST_TOL;
				end
				dmf_pkg::ST_TOL: begin
					kept_q  <= '0;
					state_q <= dmf_pkg::ST_CNT;
				end
				dmf_pkg::ST_CNT: begin
					if (sweep_end) begin
						state_q <= dmf_pkg::ST_EMIT;
					end
				end
				dmf_pkg::ST_EMIT: begin
					if (sweep_end) begin
						state_q <= dmf_pkg::ST_IDLE;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= dmf_pkg::ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[dmf_pkg::IDX_W-1:0];
		if ((state_q == dmf_pkg::ST_MED) && sweep_end && (bit_q == '0)) begin
			med_q <= rank_result ^ dmf_pkg::SIGN_FLIP;
		end
		if ((state_q == dmf_pkg::ST_MAD) && sweep_end && (bit_q == '0)) begin
			mad_q <= rank_result;
		end
		if (state_q == dmf_pkg::ST_PROD) begin
			prod_q <= dmf_pkg::PROD_W'(mad_scale_q * madq);
		end
		if (state_q == dmf_pkg::ST_TOL) begin
			tol_q <= (prod_q[dmf_pkg::PROD_W-1:4] > dmf_pkg::TOL_W'(min_tol_q))
				? prod_q[dmf_pkg::PROD_W-1:4] : dmf_pkg::TOL_W'(min_tol_q);
		end
		match_index <= idx_s1;
		keep        <= all_keep || dev_ok;
		last_res    <= ({1'b0, idx_s1} + 1'b1) == count_q;
		overflow    <= ovf_q;
	end
endmodule
`default_nettype wire

@@ hdl/dmf_checker.sv @@
// Port-level checker of the disparity median/MAD filter, bound to the top level.
// Depends on dmf_pkg and disparity_median_mad_filter_macros.svh.
`default_nettype none
`include "disparity_median_mad_filter_macros.svh"
module dmf_port_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      busy,
	input wire logic                      done,
	input wire logic [dmf_pkg::IDX_W-1:0] match_index,
	input wire logic                      last_res
);
	`DMF_ASSERT_NEXT(a_burst, done && !last_res, done, "result burst broke off early")
	`DMF_ASSERT_NEXT(a_order, done && !last_res, match_index == $past(match_index) + 1'b1, "results out of order")
	`DMF_ASSERT_NEXT(a_end, done && last_res, !done, "result after the final beat")
	`DMF_ASSERT_NOW(a_first, $rose(done), match_index == '0, "set did not start at index zero")
	`DMF_ASSERT_NOW(a_busy, done && !last_res, busy, "block idle during results")
endmodule

bind disparity_median_mad_filter dmf_port_checker u_dmf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.done        (done),
	.match_index (match_index),
	.last_res    (last_res)
);
`default_nettype wire
